### src/lhc_pkg.sv
package lhc_pkg;

  // Field and counter widths
  localparam int CNT_W      = 64;
  localparam int KIND_W     = 3;
  localparam int WORD_W     = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CLASSES    = 3;
  localparam int LIMIT_REGS = 8;
  localparam int MAX_BUCKETS = 9;

  // Word layout of one per-kind row: class counters, count, sum, buckets
  localparam int W_COUNT   = 3;
  localparam int W_SUM     = 4;
  localparam int W_BUCKET0 = 5;

  // Operation codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Read group codes
  localparam logic [1:0] GRP_CLASS  = 2'd0;
  localparam logic [1:0] GRP_COUNT  = 2'd1;
  localparam logic [1:0] GRP_SUM    = 2'd2;
  localparam logic [1:0] GRP_BUCKET = 2'd3;

  // Status classes
  localparam logic [1:0] CLS_2XX   = 2'd0;
  localparam logic [1:0] CLS_4XX   = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  // Bucket limit defaults
  localparam logic [LIMIT_REGS-1:0][CNT_W-1:0] LIMIT_RESET = {
    64'd1000000, 64'd500000, 64'd200000, 64'd100000,
    64'd50000,   64'd25000,  64'd10000,  64'd5000
  };

  typedef struct packed {
    logic              operation;
    logic [1:0]        request_kind;
    logic [9:0]        status_code;
    logic [CNT_W-1:0]  elapsed_us;
    logic [1:0]        read_group;
    logic [4:0]        read_index;
  } in_t;

  typedef struct packed {
    logic              recorded;
    logic [CNT_W-1:0]  read_value;
    logic              read_ok;
  } out_t;

  // Decoded item handed from the front end to the update stage
  typedef struct packed {
    logic                   rec;
    logic                   rd_ok;
    logic [KIND_W-1:0]      kind;
    logic [1:0]             cls;
    logic [CNT_W-1:0]       lat;
    logic [MAX_BUCKETS-1:0] hit;
    logic [WORD_W-1:0]      word;
  } item_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a);
    logic [CNT_W-1:0] r;
    r = (&a) ? a : a + CNT_W'(1);
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

### src/lhc_row_mem.sv
module lhc_row_mem #(
  parameter int DEPTH = 3,
  parameter int WIDTH = 896,
  parameter int IDX_W = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;

  // Write port and per-row valid bits; reset makes every row read as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  // Registered read port, old data on a same-row write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= valid_r[rd_idx];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### src/lhc_decode.sv
module lhc_decode #(
  parameter int KINDS   = 3,
  parameter int BUCKETS = 9
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lhc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lhc_pkg::CNT_W-1:0]        cfg_wdata,
  input  lhc_pkg::in_t                     in_data,
  output lhc_pkg::item_t                   item
);

  logic [lhc_pkg::LIMIT_REGS-1:0][lhc_pkg::CNT_W-1:0] limit_r;

  // Bucket limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lhc_pkg::LIMIT_RESET;
    end else if (cfg_we &&
                 cfg_index < lhc_pkg::CFG_IDX_W'(lhc_pkg::LIMIT_REGS)) begin
      limit_r[cfg_index[2:0]] <= cfg_wdata;
    end
  end

  logic [1:0]                      cls;
  logic [lhc_pkg::MAX_BUCKETS-1:0] hit;
  logic                            kind_ok;
  logic [lhc_pkg::KIND_W-1:0]      rd_kind;
  logic [lhc_pkg::WORD_W-1:0]      rd_word;
  logic                            rd_ok;

  // Sort status into its class
  always_comb begin
    if (in_data.status_code inside {[10'd200:10'd299]}) begin
      cls = lhc_pkg::CLS_2XX;
    end else if (in_data.status_code inside {[10'd400:10'd499]}) begin
      cls = lhc_pkg::CLS_4XX;
    end else begin
      cls = lhc_pkg::CLS_OTHER;
    end
  end

  // Compare latency against each bucket limit; last bucket always hits
  always_comb begin
    for (int b = 0; b < lhc_pkg::MAX_BUCKETS; b++) begin
      if (b == BUCKETS - 1) begin
        hit[b] = 1'b1;
      end else if (b < BUCKETS - 1) begin
        hit[b] = in_data.elapsed_us <= limit_r[3'(b)];
      end else begin
        hit[b] = 1'b0;
      end
    end
  end

  assign kind_ok = 32'(in_data.request_kind) < KINDS;

  // Split a read index into row and word
  always_comb begin
    rd_kind = '0;
    rd_word = '0;
    rd_ok   = 1'b0;
    case (in_data.read_group)
      lhc_pkg::GRP_CLASS: begin
        rd_ok   = 32'(in_data.read_index) < KINDS * lhc_pkg::CLASSES;
        rd_word = lhc_pkg::WORD_W'(in_data.read_index);
        for (int k = 1; k < KINDS; k++) begin
          if (32'(in_data.read_index) >= k * lhc_pkg::CLASSES) begin
            rd_kind = lhc_pkg::KIND_W'(k);
            rd_word = lhc_pkg::WORD_W'(32'(in_data.read_index) - k * lhc_pkg::CLASSES);
          end
        end
      end
      lhc_pkg::GRP_COUNT: begin
        rd_ok   = 32'(in_data.read_index) < KINDS;
        rd_kind = in_data.read_index[lhc_pkg::KIND_W-1:0];
        rd_word = lhc_pkg::WORD_W'(lhc_pkg::W_COUNT);
      end
      lhc_pkg::GRP_SUM: begin
        rd_ok   = 32'(in_data.read_index) < KINDS;
        rd_kind = in_data.read_index[lhc_pkg::KIND_W-1:0];
        rd_word = lhc_pkg::WORD_W'(lhc_pkg::W_SUM);
      end
      lhc_pkg::GRP_BUCKET: begin
        rd_ok   = 32'(in_data.read_index) < KINDS * BUCKETS;
        rd_word = lhc_pkg::WORD_W'(32'(in_data.read_index) + lhc_pkg::W_BUCKET0);
        for (int k = 1; k < KINDS; k++) begin
          if (32'(in_data.read_index) >= k * BUCKETS) begin
            rd_kind = lhc_pkg::KIND_W'(k);
            rd_word = lhc_pkg::WORD_W'(32'(in_data.read_index) - k * BUCKETS +
                                       lhc_pkg::W_BUCKET0);
          end
        end
      end
      default: begin
        rd_ok = 1'b0;
      end
    endcase
  end

  // Assemble the decoded item; unused rows fall back to row zero
  always_comb begin
    item.cls  = cls;
    item.lat  = in_data.elapsed_us;
    item.hit  = hit;
    item.word = rd_word;
    if (in_data.operation == lhc_pkg::OP_RECORD) begin
      item.rec   = kind_ok;
      item.rd_ok = 1'b0;
      item.kind  = kind_ok ? lhc_pkg::KIND_W'(in_data.request_kind) : '0;
    end else begin
      item.rec   = 1'b0;
      item.rd_ok = rd_ok;
      item.kind  = rd_ok ? rd_kind : '0;
    end
  end

endmodule

### src/lhc_update.sv
module lhc_update #(
  parameter int NW      = 14,
  parameter int IDX_W   = 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  lhc_pkg::item_t                   item,
  output logic                             hold,
  input  logic [NW*lhc_pkg::CNT_W-1:0]     rd_row,
  output logic                             wr_en,
  output logic [IDX_W-1:0]                 wr_idx,
  output logic [NW*lhc_pkg::CNT_W-1:0]     wr_row,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lhc_pkg::out_t                    out_data
);

  localparam int SEL_W = (NW > 1) ? $clog2(NW) : 1;

  logic                                  s1_v_r;
  lhc_pkg::item_t                        s1_r;
  logic                                  fwd_r;
  logic [NW-1:0][lhc_pkg::CNT_W-1:0]     fwd_row_r;
  logic                                  out_v_r;
  lhc_pkg::out_t                         out_r;

  logic                                  out_free;
  logic                                  s1_adv;
  logic                                  fwd_nxt;
  logic [NW-1:0][lhc_pkg::CNT_W-1:0]     row_cur;
  logic [NW-1:0][lhc_pkg::CNT_W-1:0]     row_nxt;
  lhc_pkg::out_t                         res_nxt;

  assign out_free = !out_v_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign hold     = s1_v_r && !out_free;

  // Take the row being written this edge when the next item reads the same row
  assign fwd_nxt = s1_adv && s1_r.rec && (s1_r.kind == item.kind);
  assign row_cur = fwd_r ? fwd_row_r : rd_row;

  // Bump every counter of the row that this record touches
  always_comb begin
    for (int w = 0; w < NW; w++) begin
      row_nxt[w] = row_cur[w];
      if (w < lhc_pkg::CLASSES) begin
        if (32'(s1_r.cls) == w) begin
          row_nxt[w] = lhc_pkg::sat_inc(row_cur[w]);
        end
      end else if (w == lhc_pkg::W_COUNT) begin
        row_nxt[w] = lhc_pkg::sat_inc(row_cur[w]);
      end else if (w == lhc_pkg::W_SUM) begin
        row_nxt[w] = lhc_pkg::sat_add(row_cur[w], s1_r.lat);
      end else if (s1_r.hit[w - lhc_pkg::W_BUCKET0]) begin
        row_nxt[w] = lhc_pkg::sat_inc(row_cur[w]);
      end
    end
  end

  // Result of the item in the update stage
  always_comb begin
    res_nxt.recorded   = s1_r.rec;
    res_nxt.read_ok    = s1_r.rd_ok;
    res_nxt.read_value = s1_r.rd_ok ? row_cur[s1_r.word[SEL_W-1:0]] : '0;
  end

  assign wr_en  = s1_adv && s1_r.rec;
  assign wr_idx = s1_r.kind[IDX_W-1:0];
  assign wr_row = row_nxt;

  // Stage and output valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
        fwd_r  <= fwd_nxt;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (out_free) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Stage and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r      <= item;
      fwd_row_r <= row_nxt;
    end
    if (s1_adv) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

### src/latency_histogram_counters.sv
// Pipeline: an accepted item sits in the update stage register, then in the
// output register that drives out_valid; out_stall keeps it in the update stage.
// Throughput: one item per cycle unless stalled; each does a read-modify-write
// of its kind's row in the counter memory, the row forwarded between neighbors.
// Reset: synchronous, active low; per-row valid bits clear every counter at once,
// bucket limits return to their defaults; no clearing pass.
module latency_histogram_counters #(
  parameter int KINDS   = 3,
  parameter int BUCKETS = 9
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lhc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lhc_pkg::CNT_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lhc_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lhc_pkg::out_t                   out_data
);

  localparam int NW    = lhc_pkg::W_BUCKET0 + BUCKETS;
  localparam int ROW_W = NW * lhc_pkg::CNT_W;
  localparam int IDX_W = (KINDS > 1) ? $clog2(KINDS) : 1;

  lhc_pkg::item_t     item;
  logic               accept;
  logic               hold;
  logic [ROW_W-1:0]   rd_row;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [ROW_W-1:0]   wr_row;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  // Classify, compare against limits and locate the row
  lhc_decode #(
    .KINDS   (KINDS),
    .BUCKETS (BUCKETS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .item      (item)
  );

  // One row per request kind
  lhc_row_mem #(
    .DEPTH (KINDS),
    .WIDTH (ROW_W),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_idx  (item.kind[IDX_W-1:0]),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_row)
  );

  // Modify, write back and register the result
  lhc_update #(
    .NW      (NW),
    .IDX_W   (IDX_W)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (item),
    .hold      (hold),
    .rd_row    (rd_row),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_row    (wr_row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
